// ----- hw/rtl/mpm_pkg.sv -----
package mpm_pkg;

  // Fixed-point format and screen geometry
  localparam int FRAC_BITS   = 28;
  localparam int HEIGHT      = 64;
  localparam int HEIGHT_LOG2 = $clog2(HEIGHT);

  localparam int PIX_X_W = 7;
  localparam int PIX_Y_W = 6;
  localparam int ITER_W  = 8;
  localparam int ZOOM_W  = 31;
  localparam int COORD_W = 32;

  // Mapping datapath widths
  localparam int NORM_W   = PIX_X_W + FRAC_BITS - HEIGHT_LOG2;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int MAP_P_W  = DIFF_W + ZOOM_W + 1;
  localparam int SCALED_W = MAP_P_W - FRAC_BITS;

  // Iteration datapath widths: z is clamped to Z_W bits, which never changes
  // an escape decision since anything clamped already squares far above 4.0
  localparam int Z_W  = 31;
  localparam int SQ_W = 2 * Z_W - FRAC_BITS;
  localparam int ZF_W = SQ_W + 2;

  localparam logic signed [SQ_W:0] ESCAPE_LIM =
    {{(SQ_W - FRAC_BITS - 2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_Y  = 3'd5;

  localparam logic [ITER_W-1:0]  MAX_ITER_RST = 8'd40;
  localparam logic [ZOOM_W-1:0]  ZOOM_RST     = 31'd536870912;
  localparam logic [COORD_W-1:0] OFFSET_RST   = 32'd0;
  localparam logic [COORD_W-1:0] FOCUS_X_RST  = 32'd402653184;
  localparam logic [COORD_W-1:0] FOCUS_Y_RST  = 32'd134217728;

  typedef struct packed {
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic               inside_res;
    logic [PIX_X_W-1:0] out_x;
    logic [PIX_Y_W-1:0] out_y;
  } result_t;

  // Word handed from cell to cell: squares and cross product of the current z
  typedef struct packed {
    logic                   valid;
    logic                   fin;
    logic                   in_set;
    logic [ITER_W-1:0]      count;
    logic signed [SQ_W-1:0] sx;
    logic signed [SQ_W-1:0] sy;
    logic signed [SQ_W-1:0] pxy;
  } cell_word_t;

  // Saturate a scaled coordinate to the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SCALED_W:0] v
  );
    logic [SCALED_W-COORD_W+1:0] top;
    logic signed [COORD_W-1:0]   r;
    top = v[SCALED_W:COORD_W-1];
    if (&top || ~|top) begin
      r = v[COORD_W-1:0];
    end else if (v[SCALED_W]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp a new z component to Z_W signed bits
  function automatic logic signed [Z_W-1:0] clamp_z(
    input logic signed [ZF_W-1:0] v
  );
    logic [ZF_W-Z_W:0]     top;
    logic signed [Z_W-1:0] r;
    top = v[ZF_W-1:Z_W-1];
    if (&top || ~|top) begin
      r = v[Z_W-1:0];
    end else if (v[ZF_W-1]) begin
      r = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Z_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mpm_map.sv -----
module mpm_map (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  mpm_pkg::pixel_t                        pixel,
  input  logic [mpm_pkg::ZOOM_W-1:0]             zoom,
  input  logic signed [mpm_pkg::COORD_W-1:0]     offset_x,
  input  logic signed [mpm_pkg::COORD_W-1:0]     offset_y,
  input  logic signed [mpm_pkg::COORD_W-1:0]     focus_x,
  input  logic signed [mpm_pkg::COORD_W-1:0]     focus_y,
  output logic                                   ready,
  output logic signed [mpm_pkg::COORD_W-1:0]     cx,
  output logic signed [mpm_pkg::COORD_W-1:0]     cy
);

  logic [2:0] stage;

  logic [mpm_pkg::NORM_W-1:0]              norm_x;
  logic [mpm_pkg::NORM_W-1:0]              norm_y;
  logic signed [mpm_pkg::DIFF_W-1:0]       diff_x;
  logic signed [mpm_pkg::DIFF_W-1:0]       diff_y;
  logic signed [mpm_pkg::MAP_P_W-1:0]      prod_x;
  logic signed [mpm_pkg::MAP_P_W-1:0]      prod_y;
  logic signed [mpm_pkg::SCALED_W:0]       shifted_x;
  logic signed [mpm_pkg::SCALED_W:0]       shifted_y;

  // pixel / HEIGHT in Q format is a plain shift since HEIGHT is a power of two
  assign norm_x = mpm_pkg::NORM_W'({pixel.pixel_x, {mpm_pkg::FRAC_BITS{1'b0}}}
                                   >> mpm_pkg::HEIGHT_LOG2);
  assign norm_y = mpm_pkg::NORM_W'({pixel.pixel_y, {mpm_pkg::FRAC_BITS{1'b0}}}
                                   >> mpm_pkg::HEIGHT_LOG2);

  // floor by FRAC_BITS, then subtract the pan
  assign shifted_x = (mpm_pkg::SCALED_W+1)'($signed(prod_x[mpm_pkg::MAP_P_W-1:mpm_pkg::FRAC_BITS]))
                     - (mpm_pkg::SCALED_W+1)'(offset_x);
  assign shifted_y = (mpm_pkg::SCALED_W+1)'($signed(prod_y[mpm_pkg::MAP_P_W-1:mpm_pkg::FRAC_BITS]))
                     - (mpm_pkg::SCALED_W+1)'(offset_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[1:0], go};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      diff_x <= $signed({1'b0, (mpm_pkg::DIFF_W-1)'(norm_x)}) - mpm_pkg::DIFF_W'(focus_x);
      diff_y <= $signed({1'b0, (mpm_pkg::DIFF_W-1)'(norm_y)}) - mpm_pkg::DIFF_W'(focus_y);
    end
    if (stage[0]) begin
      prod_x <= mpm_pkg::MAP_P_W'(diff_x) * mpm_pkg::MAP_P_W'($signed({1'b0, zoom}));
      prod_y <= mpm_pkg::MAP_P_W'(diff_y) * mpm_pkg::MAP_P_W'($signed({1'b0, zoom}));
    end
    if (stage[1]) begin
      cx <= mpm_pkg::sat_coord(shifted_x);
      cy <= mpm_pkg::sat_coord(shifted_y);
    end
  end

  assign ready = stage[2];

endmodule

// ----- hw/rtl/mpm_cell.sv -----
module mpm_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  mpm_pkg::cell_word_t                word_in,
  input  logic signed [mpm_pkg::COORD_W-1:0] cx,
  input  logic signed [mpm_pkg::COORD_W-1:0] cy,
  input  logic [mpm_pkg::ITER_W-1:0]         max_iterations,
  output mpm_pkg::cell_word_t                word_out
);

  mpm_pkg::cell_word_t                  word_next;
  logic signed [mpm_pkg::SQ_W:0]        mag;
  logic                                 escaped;
  logic signed [mpm_pkg::ZF_W-1:0]      zx_full;
  logic signed [mpm_pkg::ZF_W-1:0]      zy_full;
  logic signed [mpm_pkg::Z_W-1:0]       zx;
  logic signed [mpm_pkg::Z_W-1:0]       zy;
  logic signed [2*mpm_pkg::Z_W-1:0]     p_xx;
  logic signed [2*mpm_pkg::Z_W-1:0]     p_yy;
  logic signed [2*mpm_pkg::Z_W-1:0]     p_xy;

  // escape test on the squares carried in, before stepping again
  assign mag     = (mpm_pkg::SQ_W+1)'(word_in.sx) + (mpm_pkg::SQ_W+1)'(word_in.sy);
  assign escaped = mag > mpm_pkg::ESCAPE_LIM;

  assign zx_full = mpm_pkg::ZF_W'(word_in.sx) - mpm_pkg::ZF_W'(word_in.sy)
                   + mpm_pkg::ZF_W'(cx);
  assign zy_full = (mpm_pkg::ZF_W'(word_in.pxy) <<< 1) + mpm_pkg::ZF_W'(cy);
  assign zx      = mpm_pkg::clamp_z(zx_full);
  assign zy      = mpm_pkg::clamp_z(zy_full);
  assign p_xx    = (2*mpm_pkg::Z_W)'(zx) * (2*mpm_pkg::Z_W)'(zx);
  assign p_yy    = (2*mpm_pkg::Z_W)'(zy) * (2*mpm_pkg::Z_W)'(zy);
  assign p_xy    = (2*mpm_pkg::Z_W)'(zx) * (2*mpm_pkg::Z_W)'(zy);

  always_comb begin
    word_next = word_in;
    if (word_in.valid && !word_in.fin) begin
      if (escaped) begin
        word_next.fin    = 1'b1;
        word_next.in_set = 1'b0;
      end else if (word_in.count == max_iterations) begin
        word_next.fin    = 1'b1;
        word_next.in_set = 1'b1;
      end else begin
        word_next.count = word_in.count + 1'b1;
        word_next.sx    = p_xx[2*mpm_pkg::Z_W-1:mpm_pkg::FRAC_BITS];
        word_next.sy    = p_yy[2*mpm_pkg::Z_W-1:mpm_pkg::FRAC_BITS];
        word_next.pxy   = p_xy[2*mpm_pkg::Z_W-1:mpm_pkg::FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out <= '0;
    end else begin
      word_out <= word_next;
    end
  end

endmodule

// ----- hw/rtl/mandelbrot_pixel_membership.sv -----
// Mandelbrot membership test for one screen pixel.
// Input: pulse start with a pixel word while busy is low; the word is taken
// at that edge and busy stays high until the result appears. Output: the
// result word (inside flag plus the echoed pixel) is on result for exactly
// one cycle with done high; there is no back-pressure on that side.
// Configuration: cfg_we with cfg_index and cfg_data writes one register per
// cycle (0 iteration limit, 1 zoom, 2/3 offset, 4/5 focus); other indices
// are ignored. Write only while busy is low.
// Flow: the mapper takes the pixel into the complex plane, registering its
// difference to the focus, the product with the zoom and the panned,
// saturated c; then the point circulates through a ring of NUM_CELLS
// iteration cells, one z = z*z + c step per cycle. An escaping pixel
// finishes early. busy drops in the cycle done is high, so the next pixel
// can be started then.
// Reset: registers return to their defaults (limit 40, zoom 2.0, focus
// 1.5 + 0.5i, no offset) and any pixel in progress is dropped.
module mandelbrot_pixel_membership #(
  parameter int NUM_CELLS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mpm_pkg::pixel_t                     pixel,
  output logic                                done,
  output mpm_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAP  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [mpm_pkg::ITER_W-1:0]         max_iterations;
  logic [mpm_pkg::ZOOM_W-1:0]         zoom;
  logic signed [mpm_pkg::COORD_W-1:0] offset_x;
  logic signed [mpm_pkg::COORD_W-1:0] offset_y;
  logic signed [mpm_pkg::COORD_W-1:0] focus_x;
  logic signed [mpm_pkg::COORD_W-1:0] focus_y;

  logic                               accept;
  logic                               map_ready;
  logic signed [mpm_pkg::COORD_W-1:0] cx;
  logic signed [mpm_pkg::COORD_W-1:0] cy;
  mpm_pkg::pixel_t                    pix;
  mpm_pkg::cell_word_t                ring [NUM_CELLS+1];
  logic                               finish;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign finish = (state == ST_RUN) && ring[NUM_CELLS].valid && ring[NUM_CELLS].fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mpm_pkg::MAX_ITER_RST;
      zoom           <= mpm_pkg::ZOOM_RST;
      offset_x       <= mpm_pkg::OFFSET_RST;
      offset_y       <= mpm_pkg::OFFSET_RST;
      focus_x        <= mpm_pkg::FOCUS_X_RST;
      focus_y        <= mpm_pkg::FOCUS_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mpm_pkg::REG_MAX_ITER: max_iterations <= cfg_data[mpm_pkg::ITER_W-1:0];
        mpm_pkg::REG_ZOOM:     zoom           <= cfg_data[mpm_pkg::ZOOM_W-1:0];
        mpm_pkg::REG_OFFSET_X: offset_x       <= cfg_data;
        mpm_pkg::REG_OFFSET_Y: offset_y       <= cfg_data;
        mpm_pkg::REG_FOCUS_X:  focus_x        <= cfg_data;
        mpm_pkg::REG_FOCUS_Y:  focus_y        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_MAP;
      ST_MAP:  if (map_ready) state_next = ST_RUN;
      ST_RUN:  if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix <= pixel;
    end
    if (finish) begin
      result.inside_res <= ring[NUM_CELLS].in_set;
      result.out_x      <= pix.pixel_x;
      result.out_y      <= pix.pixel_y;
    end
  end

  mpm_map u_map (
    .clk      (clk),
    .rst      (rst),
    .go       (accept),
    .pixel    (pixel),
    .zoom     (zoom),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .focus_x  (focus_x),
    .focus_y  (focus_y),
    .ready    (map_ready),
    .cx       (cx),
    .cy       (cy)
  );

  // Close the ring: inject a fresh z = 0 word, recirculate, or drop when done
  always_comb begin
    ring[0] = '0;
    if (state == ST_MAP && map_ready) begin
      ring[0].valid = 1'b1;
    end else if (state == ST_RUN && !finish) begin
      ring[0] = ring[NUM_CELLS];
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mpm_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .word_in        (ring[i]),
      .cx             (cx),
      .cy             (cy),
      .max_iterations (max_iterations),
      .word_out       (ring[i+1])
    );
  end

endmodule

// ----- tb/membership_check_pkg.sv -----
`timescale 1ns / 100ps

package membership_check_pkg;
  import mpm_pkg::*;

  localparam longint PROD_SAT  = longint'(1) << 61;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));

  class membership_scoreboard;
    logic [ITER_W-1:0]         iter_limit;
    logic [ZOOM_W-1:0]         zoom;
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic signed [COORD_W-1:0] focus_x;
    logic signed [COORD_W-1:0] focus_y;
    result_t                   pending_results[$];
    int unsigned               mismatches;

    function new();
      iter_limit = MAX_ITER_RST;
      zoom       = ZOOM_RST;
      offset_x   = OFFSET_RST;
      offset_y   = OFFSET_RST;
      focus_x    = FOCUS_X_RST;
      focus_y    = FOCUS_Y_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAX_ITER: iter_limit = data[ITER_W-1:0];
        REG_ZOOM:     zoom       = data[ZOOM_W-1:0];
        REG_OFFSET_X: offset_x   = data;
        REG_OFFSET_Y: offset_y   = data;
        REG_FOCUS_X:  focus_x    = data;
        REG_FOCUS_Y:  focus_y    = data;
        default: ;
      endcase
    endfunction

    // Exact product, floored by the fraction bits, clamped far above any decision
    function longint fix_mul(longint a, longint b);
      logic signed [127:0] prod;
      prod = 128'(a);
      prod = (prod * b) >>> FRAC_BITS;
      if (prod > PROD_SAT) return PROD_SAT;
      if (prod < -PROD_SAT) return -PROD_SAT;
      return longint'(prod);
    endfunction

    function longint map_coord(logic [PIX_X_W-1:0] p, logic signed [COORD_W-1:0] focus,
                               logic signed [COORD_W-1:0] offset);
      longint norm;
      longint v;
      norm = (longint'(p) << FRAC_BITS) / HEIGHT;
      v = fix_mul(norm - longint'(focus), longint'(zoom)) - longint'(offset);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v;
    endfunction

    function logic predict_inside(pixel_t px);
      longint cx, cy, zx, zy, sx, sy, pxy;
      longint escape_lim;
      cx = map_coord(px.pixel_x, focus_x, offset_x);
      cy = map_coord({1'b0, px.pixel_y}, focus_y, offset_y);
      zx = 0;
      zy = 0;
      escape_lim = longint'(4) << FRAC_BITS;
      for (int i = 0; i < iter_limit; i++) begin
        sx  = fix_mul(zx, zx);
        sy  = fix_mul(zy, zy);
        pxy = fix_mul(zx, zy);
        zx  = sx - sy + cx;
        zy  = 2 * pxy + cy;
        if (fix_mul(zx, zx) + fix_mul(zy, zy) > escape_lim) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_pixel(pixel_t px);
      result_t r;
      r.inside_res = predict_inside(px);
      r.out_x      = px.pixel_x;
      r.out_y      = px.pixel_y;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no pixel pending: %h", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.inside_res !== want.inside_res) begin
        $error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
        mismatches++;
      end
      if (got.out_x !== want.out_x) begin
        $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
        mismatches++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import mpm_pkg::*;
  import membership_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS  = 107;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  pixel_t                pixel;
  logic                  done;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  membership_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int idle_pct;

  mandelbrot_pixel_membership u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_pixel(pixel);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int n;
    n = 0;
    while (n < 64 && $urandom_range(99) < idle_pct) n++;
    return n;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_setting(logic [31:0] iters, logic [31:0] zm, logic [31:0] ox,
                              logic [31:0] oy, logic [31:0] fx, logic [31:0] fy);
    poke_reg(REG_MAX_ITER, iters);
    poke_reg(REG_ZOOM, zm);
    poke_reg(REG_OFFSET_X, ox);
    poke_reg(REG_OFFSET_Y, oy);
    poke_reg(REG_FOCUS_X, fx);
    poke_reg(REG_FOCUS_Y, fy);
    // unmapped index: block must drop it
    poke_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_X_W-1:0] x, logic [PIX_Y_W-1:0] y);
    int gap;
    start <= 1'b1;
    pixel <= pixel_t'{pixel_x: x, pixel_y: y};
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every pending word has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    pixel     = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset view: corners, center, one odd spot
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd127, 6'd63);
    send_pixel(7'd127, 6'd0);
    send_pixel(7'd0, 6'd63);
    send_pixel(7'd64, 6'd32);
    send_pixel(7'd85, 6'd21);
    drain();

    // no iterations at all: always inside
    load_setting(32'd0, 32'(ZOOM_RST), OFFSET_RST, OFFSET_RST, FOCUS_X_RST, FOCUS_Y_RST);
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd127, 6'd63);
    send_pixel(PIX_X_W'($urandom_range(127)), PIX_Y_W'($urandom_range(63)));
    drain();

    // zero zoom: c = -offset, saturating on the real axis
    load_setting(32'd255, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, FOCUS_X_RST, FOCUS_Y_RST);
    send_pixel(7'd3, 6'd60);
    send_pixel(7'd127, 6'd1);
    drain();
    load_setting(32'd255, 32'd0, 32'd0, 32'd0, FOCUS_X_RST, FOCUS_Y_RST);
    send_pixel(7'd100, 6'd40);
    send_pixel(7'd0, 6'd0);
    drain();

    // largest zoom against extreme focus and offset: mapped c clamps
    load_setting(32'd40, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF);
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd127, 6'd63);
    send_pixel(7'd31, 6'd10);
    drain();

    load_setting(32'd1, 32'(ZOOM_RST), OFFSET_RST, OFFSET_RST, FOCUS_X_RST, FOCUS_Y_RST);
    send_pixel(7'd96, 6'd32);
    send_pixel(7'd0, 6'd32);
    send_pixel(PIX_X_W'($urandom_range(127)), PIX_Y_W'($urandom_range(63)));

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain();
      case (k % 3)
        0: idle_pct = 0;
        1: idle_pct = 85;
        default: idle_pct = 36;
      endcase
      if (k % 4 == 3) begin
        load_setting(pick_word(), pick_word(), pick_word(), pick_word(),
                     pick_word(), pick_word());
      end else begin
        // a window around the set, so most pixels iterate for a while
        load_setting($urandom_range(1, (k == 4) ? 255 : 64),
                     $urandom_range(1 << 26, 3 << 28),
                     $urandom_range(0, 1 << 27) - (1 << 26),
                     $urandom_range(0, 1 << 27) - (1 << 26),
                     (1 << 28) + $urandom_range(0, 1 << 28),
                     $urandom_range(0, 1 << 28));
      end
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(PIX_X_W'($urandom_range(127)), PIX_Y_W'($urandom_range(63)));
        if ($urandom_range(63) == 0) drain();
      end
    end

    drain();
    // catch a stray result word, waiting longer than an inside pixel can take
    repeat (300) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mpm_pkg.sv
hw/rtl/mpm_map.sv
hw/rtl/mpm_cell.sv
hw/rtl/mandelbrot_pixel_membership.sv
tb/membership_check_pkg.sv
tb/tb_top.sv
